// ===== hdl/ris_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types, widths and helpers for the ray and sphere intersection block.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int unsigned COMP_W   = 32;           // Q16.16 vector component
  localparam int unsigned PROD_W   = 2 * COMP_W;   // Q32.32 product
  localparam int unsigned C_W      = 64;           // Q32.32 c term
  localparam int unsigned DISC_W   = 128;          // Q64.64 discriminant
  localparam int unsigned ROOT_W   = DISC_W / 2;   // Q32.32 square root
  localparam int unsigned REM_W    = ROOT_W + 2;   // partial remainder
  localparam int unsigned NUM_CELLS = ROOT_W;      // one root bit per cell
  localparam int unsigned DIST_W   = 31;           // Q15.16 distance, unsigned
  localparam int unsigned FRAC_W   = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Input item as packed on in_tdata (dir_x in the lowest bits).
  typedef struct packed {
    logic signed [C_W-1:0]    c_term;
    logic signed [COMP_W-1:0] oc_z;
    logic signed [COMP_W-1:0] oc_y;
    logic signed [COMP_W-1:0] oc_x;
    logic signed [COMP_W-1:0] dir_z;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_x;
  } ris_ray_t;

  // Side data that travels down the square-root chain with each item.
  typedef struct packed {
    logic              miss;    // discriminant negative
    logic              hneg;    // sign of h = dot(oc, dir)
    logic [PROD_W-1:0] m;       // magnitude of h
  } ris_side_t;

  // Result item.
  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } ris_res_t;

  // Magnitude of a 32-bit two's complement value; the most negative value
  // maps to 2^31, which still fits the unsigned width.
  function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] v);
    return v[COMP_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== hdl/ris_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_front
// Dot product, squaring of h and the discriminant, in six pipeline stages.
// ----------------------------------------------------------------------------
module ris_front
  import ris_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  ris_ray_t             ray,
  output logic                 out_valid,
  output logic [DISC_W-1:0]    disc,
  output ris_side_t            side
);

  localparam int unsigned HALF_W = PROD_W / 2;

  // Stage A: component products as sign and magnitude
  logic                 va_r;
  logic [PROD_W-1:0]    prod_a_r [3];
  logic                 neg_a_r  [3];
  logic [C_W-1:0]       c_a_r;

  logic [COMP_W-1:0]    dmag [3];
  logic [COMP_W-1:0]    omag [3];
  logic                 dsg  [3];
  logic                 osg  [3];

  always_comb begin
    dsg[0] = ray.dir_x[COMP_W-1];  dmag[0] = mag32(ray.dir_x);
    dsg[1] = ray.dir_y[COMP_W-1];  dmag[1] = mag32(ray.dir_y);
    dsg[2] = ray.dir_z[COMP_W-1];  dmag[2] = mag32(ray.dir_z);
    osg[0] = ray.oc_x[COMP_W-1];   omag[0] = mag32(ray.oc_x);
    osg[1] = ray.oc_y[COMP_W-1];   omag[1] = mag32(ray.oc_y);
    osg[2] = ray.oc_z[COMP_W-1];   omag[2] = mag32(ray.oc_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_a_r[i] <= PROD_W'(dmag[i]) * PROD_W'(omag[i]);
        neg_a_r[i]  <= dsg[i] ^ osg[i];
      end
      c_a_r <= ray.c_term;
    end
  end

  // Stage B: split into positive and negative sums
  logic                 vb_r;
  logic [PROD_W-1:0]    pos_b_r, neg_b_r;
  logic [C_W-1:0]       c_b_r;
  logic [PROD_W-1:0]    pos_nxt, neg_nxt;

  always_comb begin
    pos_nxt = '0;
    neg_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (neg_a_r[i]) begin
        neg_nxt = neg_nxt + prod_a_r[i];
      end else begin
        pos_nxt = pos_nxt + prod_a_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_b_r <= pos_nxt;
      neg_b_r <= neg_nxt;
      c_b_r   <= c_a_r;
    end
  end

  // Stage C: sign and magnitude of h
  logic                 vc_r;
  logic                 hneg_c_r;
  logic [PROD_W-1:0]    m_c_r;
  logic [C_W-1:0]       c_c_r;
  logic                 hneg_nxt;

  assign hneg_nxt = pos_b_r < neg_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hneg_c_r <= hneg_nxt;
      m_c_r    <= hneg_nxt ? (neg_b_r - pos_b_r) : (pos_b_r - neg_b_r);
      c_c_r    <= c_b_r;
    end
  end

  // Stage D: partial products of m * m, magnitude of c
  logic                 vd_r;
  logic [PROD_W-1:0]    p00_d_r, p01_d_r, p11_d_r;
  ris_side_t            side_d_r;
  logic                 cneg_d_r;
  logic [C_W-1:0]       cmag_d_r;
  logic [HALF_W-1:0]    m_lo, m_hi;

  assign m_lo = m_c_r[HALF_W-1:0];
  assign m_hi = m_c_r[PROD_W-1:HALF_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_d_r  <= PROD_W'(m_lo) * PROD_W'(m_lo);
      p01_d_r  <= PROD_W'(m_lo) * PROD_W'(m_hi);
      p11_d_r  <= PROD_W'(m_hi) * PROD_W'(m_hi);
      side_d_r <= '{miss: 1'b0, hneg: hneg_c_r, m: m_c_r};
      cneg_d_r <= c_c_r[C_W-1];
      cmag_d_r <= c_c_r[C_W-1] ? (~c_c_r + 1'b1) : c_c_r;
    end
  end

  // Stage E: assemble h^2 in Q64.64; the cross term appears twice
  logic                 ve_r;
  logic [DISC_W-1:0]    hsq_e_r;
  ris_side_t            side_e_r;
  logic                 cneg_e_r;
  logic [C_W-1:0]       cmag_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsq_e_r  <= {p11_d_r, p00_d_r} + (DISC_W'(p01_d_r) << (HALF_W + 1));
      side_e_r <= side_d_r;
      cneg_e_r <= cneg_d_r;
      cmag_e_r <= cmag_d_r;
    end
  end

  // Stage F: disc = h^2 - c, with c moved up to Q64.64
  logic                 vf_r;
  logic [DISC_W-1:0]    disc_f_r;
  ris_side_t            side_f_r;
  logic [DISC_W-1:0]    cs;
  logic                 miss_nxt;

  assign cs       = {32'd0, cmag_e_r, 32'd0};
  assign miss_nxt = !cneg_e_r && (cs > hsq_e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cneg_e_r) begin
        disc_f_r <= hsq_e_r + cs;
      end else if (miss_nxt) begin
        disc_f_r <= '0;
      end else begin
        disc_f_r <= hsq_e_r - cs;
      end
      side_f_r <= '{miss: miss_nxt, hneg: side_e_r.hneg, m: side_e_r.m};
    end
  end

  assign out_valid = vf_r;
  assign disc      = disc_f_r;
  assign side      = side_f_r;

endmodule

// ===== hdl/ris_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_sqrt_cell
// One digit step of the restoring square root: settle one root bit.
// ----------------------------------------------------------------------------
module ris_sqrt_cell
  import ris_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [REM_W-1:0]     in_rem,
  input  logic [ROOT_W-1:0]    in_root,
  input  logic [DISC_W-1:0]    in_rad,
  input  ris_side_t            in_side,
  output logic                 out_valid,
  output logic [REM_W-1:0]     out_rem,
  output logic [ROOT_W-1:0]    out_root,
  output logic [DISC_W-1:0]    out_rad,
  output ris_side_t            out_side
);

  logic                 valid_r;
  logic [REM_W-1:0]     rem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [DISC_W-1:0]    rad_r;
  ris_side_t            side_r;

  logic [REM_W-1:0]     rem_sh, trial;
  logic                 take;

  // Bring down the next two radicand bits; the remainder's top bits stay clear.
  assign rem_sh = {in_rem[REM_W-3:0], in_rad[DISC_W-1 -: 2]};
  assign trial  = {in_root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {in_root[ROOT_W-2:0], take};
      rad_r  <= {in_rad[DISC_W-3:0], 2'b00};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

// ===== hdl/ris_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_finish
// Pick entry or exit root, scale to Q15.16 and saturate.
// ----------------------------------------------------------------------------
module ris_finish
  import ris_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [ROOT_W-1:0]    root,
  input  ris_side_t            side,
  output logic                 out_valid,
  output ris_res_t             res
);

  localparam int unsigned SH_W = ROOT_W - FRAC_W;

  logic                 valid_r;
  ris_res_t             res_r;

  logic [ROOT_W:0]      sum;
  logic [ROOT_W-1:0]    t;
  logic                 found;
  logic [SH_W-1:0]      t_sh;
  ris_res_t             res_nxt;

  assign sum = {1'b0, side.m} + {1'b0, root};

  always_comb begin
    t     = '0;
    found = 1'b0;
    if ((side.hneg || side.m == '0) && side.m >= root) begin
      t     = side.m - root;                           // entry root
      found = 1'b1;
    end else if (side.hneg) begin
      t     = sum[ROOT_W] ? {ROOT_W{1'b1}} : sum[ROOT_W-1:0];  // exit root
      found = 1'b1;
    end else if (root >= side.m) begin
      t     = root - side.m;                           // exit root
      found = 1'b1;
    end
    t_sh = t[ROOT_W-1:FRAC_W];
    res_nxt.hit      = found && !side.miss;
    res_nxt.distance = '0;
    if (res_nxt.hit) begin
      res_nxt.distance = (|t_sh[SH_W-1:DIST_W]) ? DIST_MAX : t_sh[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== hdl/ray_sphere_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against sphere test by the quadratic formula, one ray per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one ray item per clock while the output side is not stalled and
// returns one result item per ray, in order. Six stages form h = dot(oc, dir),
// h^2 (from 32x32 partial products) and the Q64.64 discriminant h^2 - c, a
// chain of 64 identical square-root cells settles one root bit per cell, one
// stage picks the entry or exit distance, and the output register presents
// it. The sustained rate is one item per cycle while the output is not held,
// with the square-root chain taking a new radicand each clock.
// The whole pipeline advances together; a skid register at the output catches
// the item that leaves the pipeline while the output is held, and in_tready
// drops for as long as that register is full. in_tready is a register output
// and does not depend combinationally on out_tready.
// ----------------------------------------------------------------------------
module ray_sphere_intersect
  import ris_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // dir_x, dir_y, dir_z, oc_x, oc_y, oc_z, c_term
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // distance[30:0], zero pad
  output logic [0:0]   out_tuser   // hit
);

  // Pipeline advance: held while the skid register is full.
  logic en;

  logic out_valid_r, skid_valid_r;
  ris_res_t out_r, skid_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Front end: dot product, h^2 and discriminant
  logic [DISC_W-1:0] front_disc;
  ris_side_t         front_side;
  logic              front_valid;

  ris_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .ray       (ris_ray_t'(in_tdata)),
    .out_valid (front_valid),
    .disc      (front_disc),
    .side      (front_side)
  );

  // Square-root chain; index 0 is the chain input
  logic              cv    [NUM_CELLS+1];
  logic [REM_W-1:0]  crem  [NUM_CELLS+1];
  logic [ROOT_W-1:0] croot [NUM_CELLS+1];
  logic [DISC_W-1:0] crad  [NUM_CELLS+1];
  ris_side_t         cside [NUM_CELLS+1];

  assign cv[0]    = front_valid;
  assign crem[0]  = '0;
  assign croot[0] = '0;
  assign crad[0]  = front_disc;
  assign cside[0] = front_side;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ris_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[k]),
      .in_rem    (crem[k]),
      .in_root   (croot[k]),
      .in_rad    (crad[k]),
      .in_side   (cside[k]),
      .out_valid (cv[k+1]),
      .out_rem   (crem[k+1]),
      .out_root  (croot[k+1]),
      .out_rad   (crad[k+1]),
      .out_side  (cside[k+1])
    );
  end

  // Root selection and saturation
  logic     fin_valid;
  ris_res_t fin_res;

  ris_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cv[NUM_CELLS]),
    .root      (croot[NUM_CELLS]),
    .side      (cside[NUM_CELLS]),
    .out_valid (fin_valid),
    .res       (fin_res)
  );

  // Output register and skid register.
  // Drain the skid first; otherwise load the output, or park the item in the
  // skid when the output is held.
  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_r <= skid_r;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        out_r <= fin_res;
      end else begin
        skid_r <= fin_res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.distance};
  assign out_tuser  = out_r.hit;

  // A full skid register always sits behind a presented result.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output empty");

  // Ready only drops after a result was held at the output.
  a_ready_drop : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_valid_r && !out_tready))
    else $error("input ready dropped without output back-pressure");

  // A miss carries a zero distance.
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |-> (out_r.distance == '0))
    else $error("miss result with non-zero distance");

endmodule
